// ===== rtl/core/tagged_value_stack_engine_unit_macros.svh =====
// assertion macros shared by the stack engine checker
// clocked on clk_i and disabled while rst_ni is low, names taken from the using scope
`ifndef TAGGED_VALUE_STACK_ENGINE_UNIT_MACROS_SVH
`define TAGGED_VALUE_STACK_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define TVSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tvse_pkg.sv =====
// shared constants, codes and controller/datapath bundles of the tagged value stack engine
// no dependencies
package tvse_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int MODE_W   = 3;
  localparam int IDX_W    = 9;
  localparam int SHIFT_W  = 10;
  localparam int TAG_W    = 3;
  localparam int PAY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 9;

  // signed width that holds an index plus the live count
  localparam int ABS_W  = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int STEP_W = $clog2(SHIFT_W + 1);

  localparam logic signed [ABS_W-1:0] DEPTH_S = ABS_W'(STACK_DEPTH);

  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GET     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROTATE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SET_TOP = 3'd5;

  localparam logic [TAG_W-1:0] TAG_NIL  = 3'd0;
  localparam logic [TAG_W-1:0] TAG_MAX  = 3'd4;
  localparam logic [TAG_W-1:0] TAG_NONE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADINDEX  = 2'd3;

  // reversal passes of a rotate
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_HEAD = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TAIL = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ALL  = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PAY_W-1:0] payload;
  } slot_t;

  typedef struct packed {
    logic                capture;
    logic                res_ld;
    logic [STATUS_W-1:0] res_status;
    logic                res_rd;
    logic                res_none;
    logic                push_wr;
    logic                pop;
    logic                get_rd;
    logic                set_wr;
    logic                fill_wr;
    logic                trunc;
    logic                mod_start;
    logic                m_load;
    logic                rng_load;
    logic [PHASE_W-1:0]  rng_sel;
    logic                rd_lo;
    logic                rd_hi;
    logic                hold;
    logic                wr_lo;
    logic                wr_hi;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              a_ok;
    logic              a_neg;
    logic              a_over;
    logic              fill_more;
    logic              shrink;
    logic              mod_done;
    logic              rng_more;
    logic              out_free;
  } sts_t;

endpackage

// ===== rtl/core/tvse_rem.sv =====
// bit-serial remainder unit, one dividend bit per cycle
// depends on tvse_pkg
module tvse_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tvse_pkg::SHIFT_W-1:0] dividend_i,
  input  logic [tvse_pkg::CNT_W-1:0]   divisor_i,
  output logic                       done_o,
  output logic [tvse_pkg::CNT_W-1:0]   rem_o
);

  logic [tvse_pkg::STEP_W-1:0]  step_q;
  logic [tvse_pkg::SHIFT_W-1:0] dvd_q;
  logic [tvse_pkg::CNT_W-1:0]   dvs_q;
  logic [tvse_pkg::CNT_W-1:0]   rem_q;
  logic [tvse_pkg::CNT_W-1:0]   rem_d;
  logic [tvse_pkg::CNT_W:0]     trial;
  logic [tvse_pkg::CNT_W:0]     dvs_ext;

  always_comb begin
    trial   = {rem_q, dvd_q[tvse_pkg::SHIFT_W-1]};
    dvs_ext = {1'b0, dvs_q};
    if (trial >= dvs_ext) begin
      rem_d = tvse_pkg::CNT_W'(trial - dvs_ext);
    end else begin
      rem_d = trial[tvse_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= tvse_pkg::STEP_W'(tvse_pkg::SHIFT_W);
    end else if (step_q != '0) begin
      step_q <= step_q - tvse_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (step_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[tvse_pkg::SHIFT_W-2:0], 1'b0};
    end
  end

  assign done_o = (step_q == '0);
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/tvse_dp.sv =====
// datapath: slot memory, live count, request and result registers, swap and range logic
// depends on tvse_pkg and tvse_rem
module tvse_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tvse_pkg::cmd_t                cmd_i,
  output tvse_pkg::sts_t                sts_o,
  input  logic [tvse_pkg::MODE_W-1:0]   mode_i,
  input  logic signed [tvse_pkg::IDX_W-1:0]   slot_index_i,
  input  logic signed [tvse_pkg::SHIFT_W-1:0] shift_count_i,
  input  logic [tvse_pkg::TAG_W-1:0]    value_tag_i,
  input  logic [tvse_pkg::PAY_W-1:0]    value_payload_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [tvse_pkg::STATUS_W-1:0] status_o,
  output logic [tvse_pkg::TAG_W-1:0]    out_tag_o,
  output logic [tvse_pkg::PAY_W-1:0]    out_payload_o,
  output logic [tvse_pkg::DEPTH_W-1:0]  depth_now_o
);

  // request registers
  logic [tvse_pkg::MODE_W-1:0]        mode_q;
  logic signed [tvse_pkg::ABS_W-1:0]  a_q;
  logic [tvse_pkg::SHIFT_W-1:0]       shift_q;
  tvse_pkg::slot_t                    val_q;

  logic [tvse_pkg::CNT_W-1:0]         count_q;
  logic signed [tvse_pkg::ABS_W-1:0]  count_s;
  logic signed [tvse_pkg::ABS_W-1:0]  idx_s;
  logic signed [tvse_pkg::ABS_W-1:0]  a_in;
  tvse_pkg::slot_t                    val_in;
  logic                               tag_ok;

  logic [tvse_pkg::ADDR_W-1:0]        a_idx;
  logic [tvse_pkg::CNT_W-1:0]         a_cnt;
  logic [tvse_pkg::CNT_W-1:0]         last;

  // slot memory
  tvse_pkg::slot_t                    mem [tvse_pkg::STACK_DEPTH];
  tvse_pkg::slot_t                    rd_data_q;
  tvse_pkg::slot_t                    hold_q;
  tvse_pkg::slot_t                    wd;
  logic                               we;
  logic                               re;
  logic [tvse_pkg::ADDR_W-1:0]        wa;
  logic [tvse_pkg::ADDR_W-1:0]        ra;

  // rotate bookkeeping
  logic [tvse_pkg::CNT_W-1:0]         lo_q;
  logic [tvse_pkg::CNT_W-1:0]         hi_q;
  logic [tvse_pkg::CNT_W-1:0]         m_q;
  logic [tvse_pkg::CNT_W-1:0]         len_q;
  logic [tvse_pkg::CNT_W-1:0]         len_in;
  logic [tvse_pkg::CNT_W-1:0]         rem;
  logic [tvse_pkg::CNT_W-1:0]         k;
  logic [tvse_pkg::SHIFT_W-1:0]       shift_mag;
  logic                               shift_neg;
  logic                               mod_done;

  // result staging and output register
  logic [tvse_pkg::STATUS_W-1:0]      res_status_q;
  logic                               res_rd_q;
  logic                               res_none_q;
  logic                               out_valid_q;
  logic [tvse_pkg::STATUS_W-1:0]      out_status_q;
  logic [tvse_pkg::TAG_W-1:0]         out_tag_q;
  logic [tvse_pkg::PAY_W-1:0]         out_payload_q;
  logic [tvse_pkg::DEPTH_W-1:0]       out_depth_q;

  assign count_s = tvse_pkg::ABS_W'(count_q);
  assign idx_s   = tvse_pkg::ABS_W'(slot_index_i);
  assign a_in    = slot_index_i[tvse_pkg::IDX_W-1] ? (idx_s + count_s) : idx_s;

  // nil and unknown tags are stored as a clean nil
  assign tag_ok = (value_tag_i != tvse_pkg::TAG_NIL) && (value_tag_i <= tvse_pkg::TAG_MAX);
  assign val_in.tag     = tag_ok ? value_tag_i : tvse_pkg::TAG_NIL;
  assign val_in.payload = tag_ok ? value_payload_i : '0;

  assign a_idx = a_q[tvse_pkg::ADDR_W-1:0];
  assign a_cnt = a_q[tvse_pkg::CNT_W-1:0];
  assign last  = count_q - tvse_pkg::CNT_W'(1);

  assign shift_neg = shift_q[tvse_pkg::SHIFT_W-1];
  assign shift_mag = shift_neg ? (~shift_q + tvse_pkg::SHIFT_W'(1)) : shift_q;
  assign len_in    = count_q - a_cnt;
  assign k         = (shift_neg && (rem != '0)) ? (len_q - rem) : rem;

  tvse_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (shift_mag),
    .divisor_i  (len_in),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      a_q     <= a_in;
      shift_q <= shift_count_i;
      val_q   <= val_in;
    end
    if (cmd_i.mod_start) begin
      len_q <= len_in;
    end
    if (cmd_i.m_load) begin
      m_q <= last - k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.push_wr || cmd_i.fill_wr) begin
      count_q <= count_q + tvse_pkg::CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_q <= last;
    end else if (cmd_i.trunc) begin
      count_q <= a_cnt;
    end
  end

  // swap ranges for the three reversals
  always_ff @(posedge clk_i) begin
    if (cmd_i.rng_load) begin
      case (cmd_i.rng_sel)
        tvse_pkg::PH_HEAD: begin
          lo_q <= a_cnt;
          hi_q <= m_q;
        end
        tvse_pkg::PH_TAIL: begin
          lo_q <= m_q + tvse_pkg::CNT_W'(1);
          hi_q <= last;
        end
        default: begin
          lo_q <= a_cnt;
          hi_q <= last;
        end
      endcase
    end else if (cmd_i.wr_hi) begin
      lo_q <= lo_q + tvse_pkg::CNT_W'(1);
      hi_q <= hi_q - tvse_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = count_q[tvse_pkg::ADDR_W-1:0];
    wd = val_q;
    if (cmd_i.push_wr) begin
      we = 1'b1;
    end else if (cmd_i.fill_wr) begin
      we = 1'b1;
      wd = '0;
    end else if (cmd_i.set_wr) begin
      we = 1'b1;
      wa = a_idx;
    end else if (cmd_i.wr_lo) begin
      we = 1'b1;
      wa = lo_q[tvse_pkg::ADDR_W-1:0];
      wd = rd_data_q;
    end else if (cmd_i.wr_hi) begin
      we = 1'b1;
      wa = hi_q[tvse_pkg::ADDR_W-1:0];
      wd = hold_q;
    end
  end

  always_comb begin
    re = 1'b0;
    ra = last[tvse_pkg::ADDR_W-1:0];
    if (cmd_i.pop) begin
      re = 1'b1;
    end else if (cmd_i.get_rd) begin
      re = 1'b1;
      ra = a_idx;
    end else if (cmd_i.rd_lo) begin
      re = 1'b1;
      ra = lo_q[tvse_pkg::ADDR_W-1:0];
    end else if (cmd_i.rd_hi) begin
      re = 1'b1;
      ra = hi_q[tvse_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
    if (cmd_i.hold) begin
      hold_q <= rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      res_status_q <= cmd_i.res_status;
      res_rd_q     <= cmd_i.res_rd;
      res_none_q   <= cmd_i.res_none;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_tag_q     <= res_rd_q ? rd_data_q.tag
                               : (res_none_q ? tvse_pkg::TAG_NONE : tvse_pkg::TAG_NIL);
      out_payload_q <= res_rd_q ? rd_data_q.payload : '0;
      out_depth_q   <= tvse_pkg::DEPTH_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.full      = (count_q >= tvse_pkg::CNT_W'(tvse_pkg::STACK_DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.a_neg     = a_q[tvse_pkg::ABS_W-1];
  assign sts_o.a_ok      = !a_q[tvse_pkg::ABS_W-1] && (a_q < count_s);
  assign sts_o.a_over    = (a_q > tvse_pkg::DEPTH_S);
  assign sts_o.fill_more = (count_s < a_q);
  assign sts_o.shrink    = (count_s > a_q);
  assign sts_o.mod_done  = mod_done;
  assign sts_o.rng_more  = (lo_q < hi_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_tag_o     = out_tag_q;
  assign out_payload_o = out_payload_q;
  assign depth_now_o   = out_depth_q;

endmodule

// ===== rtl/core/tvse_ctrl.sv =====
// controller state machine: decodes a request and sequences the datapath
// depends on tvse_pkg
module tvse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  tvse_pkg::sts_t sts_i,
  output logic           in_stall_o,
  output tvse_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_DONE = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_RNG  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_SWA  = 4'd6;
  localparam logic [3:0] S_SWB  = 4'd7;
  localparam logic [3:0] S_SWC  = 4'd8;
  localparam logic [3:0] S_SWD  = 4'd9;
  localparam logic [3:0] S_FILL = 4'd10;

  logic [3:0]                   state_q;
  logic [3:0]                   state_d;
  logic [tvse_pkg::PHASE_W-1:0] phase_q;
  logic [tvse_pkg::PHASE_W-1:0] phase_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.res_ld     = 1'b1;
        cmd_o.res_status = tvse_pkg::ST_OK;
        state_d          = S_DONE;
        unique case (sts_i.mode)
          tvse_pkg::MODE_PUSH: begin
            if (sts_i.full) begin
              cmd_o.res_status = tvse_pkg::ST_OVERFLOW;
            end else begin
              cmd_o.push_wr = 1'b1;
            end
          end
          tvse_pkg::MODE_POP: begin
            if (sts_i.empty) begin
              cmd_o.res_status = tvse_pkg::ST_UNDERFLOW;
              cmd_o.res_none   = 1'b1;
            end else begin
              cmd_o.pop    = 1'b1;
              cmd_o.res_rd = 1'b1;
            end
          end
          tvse_pkg::MODE_GET: begin
            if (sts_i.a_ok) begin
              cmd_o.get_rd = 1'b1;
              cmd_o.res_rd = 1'b1;
            end
          end
          tvse_pkg::MODE_SET: begin
            if (sts_i.a_ok) begin
              cmd_o.set_wr = 1'b1;
            end else begin
              cmd_o.res_status = tvse_pkg::ST_BADINDEX;
            end
          end
          tvse_pkg::MODE_ROTATE: begin
            if (sts_i.a_ok) begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_MOD;
            end else begin
              cmd_o.res_status = tvse_pkg::ST_BADINDEX;
            end
          end
          tvse_pkg::MODE_SET_TOP: begin
            if (sts_i.a_neg) begin
              cmd_o.res_status = tvse_pkg::ST_BADINDEX;
            end else if (sts_i.a_over) begin
              cmd_o.res_status = tvse_pkg::ST_OVERFLOW;
            end else if (sts_i.fill_more) begin
              state_d = S_FILL;
            end else if (sts_i.shrink) begin
              cmd_o.trunc = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          in_stall_o     = 1'b0;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = S_DEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.m_load = 1'b1;
          phase_d      = tvse_pkg::PH_HEAD;
          state_d      = S_RNG;
        end
      end
      S_RNG: begin
        cmd_o.rng_load = 1'b1;
        cmd_o.rng_sel  = phase_q;
        state_d        = S_CHK;
      end
      S_CHK: begin
        if (sts_i.rng_more) begin
          state_d = S_SWA;
        end else begin
          unique case (phase_q)
            tvse_pkg::PH_HEAD: begin
              phase_d = tvse_pkg::PH_TAIL;
              state_d = S_RNG;
            end
            tvse_pkg::PH_TAIL: begin
              phase_d = tvse_pkg::PH_ALL;
              state_d = S_RNG;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SWA: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = S_SWB;
      end
      S_SWB: begin
        cmd_o.rd_hi = 1'b1;
        cmd_o.hold  = 1'b1;
        state_d     = S_SWC;
      end
      S_SWC: begin
        cmd_o.wr_lo = 1'b1;
        state_d     = S_SWD;
      end
      S_SWD: begin
        cmd_o.wr_hi = 1'b1;
        state_d     = S_CHK;
      end
      S_FILL: begin
        if (sts_i.fill_more) begin
          cmd_o.fill_wr = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= tvse_pkg::PH_HEAD;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/core/tagged_value_stack_engine_unit.sv =====
// top level of the tagged value stack engine; needs tvse_pkg, tvse_ctrl, tvse_dp and tvse_rem
// push, pop, get, set, set_top without growth and unused modes: word accepted in idle or done,
// decoded in the decode state and handed to the output register from the done state, which
// takes the next word only once the output register is free; a stalled result holds it in done
// rotate: remainder, then at most len swaps in three reversals; growing set_top fills nils in turn
// reset clears the live count and the handshake state; slot memory is not cleared
module tagged_value_stack_engine_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tvse_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [tvse_pkg::IDX_W-1:0]   slot_index_i,
  input  logic signed [tvse_pkg::SHIFT_W-1:0] shift_count_i,
  input  logic [tvse_pkg::TAG_W-1:0]          value_tag_i,
  input  logic [tvse_pkg::PAY_W-1:0]          value_payload_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tvse_pkg::STATUS_W-1:0]       status_o,
  output logic [tvse_pkg::TAG_W-1:0]          out_tag_o,
  output logic [tvse_pkg::PAY_W-1:0]          out_payload_o,
  output logic [tvse_pkg::DEPTH_W-1:0]        depth_now_o
);

  // commands from the controller, status back from the datapath
  tvse_pkg::cmd_t cmd;
  tvse_pkg::sts_t sts;

  // controller: one request at a time; the done state hands the result word to the
  // output register and can take the next request word in the same cycle
  tvse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // datapath: slot memory with registered read, live count, rotate remainder unit
  // and the output register that keeps a finished word while the sink stalls
  tvse_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .slot_index_i    (slot_index_i),
    .shift_count_i   (shift_count_i),
    .value_tag_i     (value_tag_i),
    .value_payload_i (value_payload_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .out_tag_o       (out_tag_o),
    .out_payload_o   (out_payload_o),
    .depth_now_o     (depth_now_o)
  );

endmodule

// ===== rtl/core/tvse_checker.sv =====
// port-level checks of the stack engine result channel, bound to the top level
// depends on tvse_pkg and tagged_value_stack_engine_unit_macros.svh
`include "tagged_value_stack_engine_unit_macros.svh"

module tvse_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_stall_i,
  input logic [tvse_pkg::STATUS_W-1:0]       status_i,
  input logic [tvse_pkg::TAG_W-1:0]          out_tag_i,
  input logic [tvse_pkg::PAY_W-1:0]          out_payload_i,
  input logic [tvse_pkg::DEPTH_W-1:0]        depth_now_i
);

  // a stalled word stays offered
  `TVSE_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i, "result word dropped")

  // underflow only on an empty stack and reports no slot
  `TVSE_ASSERT_NOW(a_underflow, out_valid_i && (status_i == tvse_pkg::ST_UNDERFLOW), (out_tag_i == tvse_pkg::TAG_NONE) && (depth_now_i == '0), "bad underflow word")

  // nil always carries a zero payload
  `TVSE_ASSERT_NOW(a_nil_zero, out_valid_i && (out_tag_i == tvse_pkg::TAG_NIL), out_payload_i == '0, "nil with payload")

  // depth never passes the stack size
  `TVSE_ASSERT_NOW(a_depth_max, out_valid_i, depth_now_i <= tvse_pkg::STACK_DEPTH, "depth beyond stack size")

endmodule

bind tagged_value_stack_engine_unit tvse_checker u_tvse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_i      (status_o),
  .out_tag_i     (out_tag_o),
  .out_payload_i (out_payload_o),
  .depth_now_i   (depth_now_o)
);

// ===== bench/tb_tagged_value_stack_engine_unit.sv =====
`timescale 1ns / 100ps
// self-checking bench for the tagged value stack engine: directed corner words, then random
// stack traffic predicted by a mirror of the stack; needs tvse_pkg and the engine rtl
module tb_tagged_value_stack_engine_unit;
  import tvse_pkg::*;

  // modes and tags the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;
  localparam logic [TAG_W-1:0]  TAG_BOOL      = 3'd1;
  localparam logic [TAG_W-1:0]  TAG_NUMBER    = 3'd2;
  localparam logic [TAG_W-1:0]  TAG_INTEGER   = 3'd3;
  localparam logic [TAG_W-1:0]  TAG_STRING    = 3'd4;
  localparam logic [TAG_W-1:0]  TAG_UNUSED_7  = 3'd7;

  localparam int RANDOM_WORDS = 1150;
  localparam int DRAIN_CYCLES = 32;

  typedef struct {
    logic [MODE_W-1:0] mode;
    int                idx;
    int                shift;
    logic [TAG_W-1:0]  tag;
    logic [PAY_W-1:0]  payload;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [PAY_W-1:0]    payload;
    logic [DEPTH_W-1:0]  depth;
  } result_t;

  // mirror of the stack: updated on every accepted request word, holds the result words owed
  class stack_mirror;
    logic [TAG_W-1:0] tags [STACK_DEPTH];
    logic [PAY_W-1:0] pays [STACK_DEPTH];
    int               live;
    int               errors;
    result_t          pending_words [$];

    function new();
      for (int i = 0; i < STACK_DEPTH; i++) begin
        tags[i] = TAG_NIL;
        pays[i] = '0;
      end
      live   = 0;
      errors = 0;
    endfunction

    function void reverse_span(int lo, int hi);
      logic [TAG_W-1:0] t;
      logic [PAY_W-1:0] p;
      while (lo < hi) begin
        t = tags[lo];
        p = pays[lo];
        tags[lo] = tags[hi];
        pays[lo] = pays[hi];
        tags[hi] = t;
        pays[hi] = p;
        lo++;
        hi--;
      end
    endfunction

    function void apply_request(request_t r);
      result_t          res;
      int               a;
      int               len;
      int               k;
      int               m;
      bit               in_range;
      logic [TAG_W-1:0] t;
      logic [PAY_W-1:0] p;
      res.status  = ST_OK;
      res.tag     = TAG_NIL;
      res.payload = '0;
      a = (r.idx >= 0) ? r.idx : r.idx + live;
      in_range = (a >= 0) && (a < live);
      t = r.tag;
      p = r.payload;
      // nil and unknown tags are stored as a clean nil
      if (t == TAG_NIL || t > TAG_MAX) begin
        t = TAG_NIL;
        p = '0;
      end
      case (r.mode)
        MODE_PUSH: begin
          if (live >= STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            tags[live] = t;
            pays[live] = p;
            live++;
          end
        end
        MODE_POP: begin
          if (live < 1) begin
            res.status = ST_UNDERFLOW;
            res.tag    = TAG_NONE;
          end else begin
            live--;
            res.tag     = tags[live];
            res.payload = pays[live];
            tags[live]  = TAG_NIL;
            pays[live]  = '0;
          end
        end
        MODE_GET: begin
          if (in_range) begin
            res.tag     = tags[a];
            res.payload = pays[a];
          end
        end
        MODE_SET: begin
          if (in_range) begin
            tags[a] = t;
            pays[a] = p;
          end else begin
            res.status = ST_BADINDEX;
          end
        end
        MODE_ROTATE: begin
          if (!in_range) begin
            res.status = ST_BADINDEX;
          end else begin
            // three reversals turn the segment a..top by k places toward the top
            len = live - a;
            k = r.shift % len;
            if (k < 0) k += len;
            m = live - 1 - k;
            reverse_span(a, m);
            reverse_span(m + 1, live - 1);
            reverse_span(a, live - 1);
          end
        end
        MODE_SET_TOP: begin
          if (a < 0) begin
            res.status = ST_BADINDEX;
          end else if (a > STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            while (live < a) begin
              tags[live] = TAG_NIL;
              pays[live] = '0;
              live++;
            end
            while (live > a) begin
              live--;
              tags[live] = TAG_NIL;
              pays[live] = '0;
            end
          end
        end
        default: begin
        end
      endcase
      res.depth = DEPTH_W'(live);
      pending_words.push_back(res);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending: status %0d tag %0d depth %0d",
               got.status, got.tag, got.depth);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.tag !== want.tag) begin
        $error("out_tag: expected %0d, got %0d", want.tag, got.tag);
        errors++;
      end
      if (got.payload !== want.payload) begin
        $error("out_payload: expected %h, got %h", want.payload, got.payload);
        errors++;
      end
      if (got.depth !== want.depth) begin
        $error("depth_now: expected %0d, got %0d", want.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [MODE_W-1:0]          mode_i;
  logic signed [IDX_W-1:0]    slot_index_i;
  logic signed [SHIFT_W-1:0]  shift_count_i;
  logic [TAG_W-1:0]           value_tag_i;
  logic [PAY_W-1:0]           value_payload_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [STATUS_W-1:0]        status_o;
  logic [TAG_W-1:0]           out_tag_o;
  logic [PAY_W-1:0]           out_payload_o;
  logic [DEPTH_W-1:0]         depth_now_o;

  stack_mirror book;
  // calm stretches turn off idling and stalls on both sides
  bit          calm;

  tagged_value_stack_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .slot_index_i    (slot_index_i),
    .shift_count_i   (shift_count_i),
    .value_tag_i     (value_tag_i),
    .value_payload_i (value_payload_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .out_tag_o       (out_tag_o),
    .out_payload_o   (out_payload_o),
    .depth_now_o     (depth_now_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic request_t make_request(logic [MODE_W-1:0] mode, int idx, int shift,
                                            logic [TAG_W-1:0] tag, logic [PAY_W-1:0] payload);
    request_t r;
    r.mode    = mode;
    r.idx     = idx;
    r.shift   = shift;
    r.tag     = tag;
    r.payload = payload;
    return r;
  endfunction

  // index mostly inside the live range, then just past either end, then anything
  function automatic int pick_index(int live);
    int roll;
    roll = $urandom_range(0, 99);
    if (live > 0 && roll < 40) return int'($urandom_range(0, live - 1));
    if (live > 0 && roll < 75) return -int'($urandom_range(1, live));
    if (roll < 85) return (roll % 2 == 0) ? live : -live - 1;
    return int'($urandom_range(0, 511)) - 256;
  endfunction

  // set_top target: near the current depth, a shrink, a too-deep relative, one short of full, or anything
  function automatic int pick_target(int live);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return int'($urandom_range(0, (live + 12 > 255) ? 255 : live + 12));
    if (roll < 70) return int'($urandom_range(0, live / 2));
    if (roll < 85) return -int'($urandom_range(1, live + 4));
    if (roll < 88) return 255;
    return int'($urandom_range(0, 511)) - 256;
  endfunction

  function automatic request_t random_request(int live);
    request_t r;
    int       roll;
    int       push_w;
    roll = $urandom_range(0, 99);
    // pushes dominate while shallow, pops once deep, so rotates stay affordable
    push_w = (live > 96) ? 12 : 28;
    if (roll < push_w) r.mode = MODE_PUSH;
    else if (roll < push_w + 18) r.mode = MODE_POP;
    else if (roll < push_w + 38) r.mode = MODE_GET;
    else if (roll < push_w + 52) r.mode = MODE_SET;
    else if (roll < push_w + 60) r.mode = MODE_ROTATE;
    else if (roll < push_w + 68) r.mode = MODE_SET_TOP;
    else if (roll < push_w + 69) r.mode = MODE_UNUSED_6;
    else if (roll < push_w + 70) r.mode = MODE_UNUSED_7;
    else r.mode = MODE_POP;
    r.idx = (r.mode == MODE_SET_TOP) ? pick_target(live) : pick_index(live);
    // keep the index inside what the 9-bit port can carry
    if (r.idx > 255) r.idx = 255;
    if (r.idx < -256) r.idx = -256;
    r.shift = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, 16)) - 8
                                           : int'($urandom_range(0, 512)) - 256;
    r.tag = ($urandom_range(0, 99) < 80) ? TAG_W'($urandom_range(1, 4))
                                         : TAG_W'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 10) r.payload = '1;
    else if (roll < 15) r.payload = '0;
    else r.payload = {$urandom, $urandom};
    return r;
  endfunction

  // present one request word, hold it until accepted, then book it in the mirror
  task automatic send_request(request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= r.mode;
    slot_index_i    <= IDX_W'(r.idx);
    shift_count_i   <= SHIFT_W'(r.shift);
    value_tag_i     <= r.tag;
    value_payload_i <= r.payload;
    do @(posedge clk_i); while (in_stall_o);
    book.apply_request(r);
  endtask

  // result side stall: random bursts, quiet during calm stretches
  initial begin
    int hold;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // every accepted result word is checked against the oldest owed one
  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.status  = status_o;
      seen.tag     = out_tag_o;
      seen.payload = out_payload_o;
      seen.depth   = depth_now_o;
      book.check_word(seen);
    end
  end

  initial begin
    request_t r;
    int       counted;
    book            = new();
    calm            = 1'b0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    mode_i          <= MODE_PUSH;
    slot_index_i    <= '0;
    shift_count_i   <= '0;
    value_tag_i     <= TAG_NIL;
    value_payload_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack: underflow, nil read, bad set, bad rotate
    send_request(make_request(MODE_POP, 0, 0, TAG_NIL, '0));
    send_request(make_request(MODE_GET, 0, 0, TAG_NIL, '0));
    send_request(make_request(MODE_SET, 0, 0, TAG_NUMBER, 64'h1));
    send_request(make_request(MODE_ROTATE, 0, 1, TAG_NIL, '0));
    // pushes, including nil with a payload and an unknown tag that both store as nil
    send_request(make_request(MODE_PUSH, 0, 0, TAG_STRING, '1));
    send_request(make_request(MODE_PUSH, 0, 0, TAG_NIL, 64'hdead_beef_0000_0001));
    send_request(make_request(MODE_PUSH, 0, 0, TAG_UNUSED_7, 64'h5555_aaaa_5555_aaaa));
    send_request(make_request(MODE_PUSH, 0, 0, TAG_BOOL, 64'h1));
    send_request(make_request(MODE_PUSH, 0, 0, TAG_NUMBER, 64'h8000_0000_0000_0000));
    // reads at the top, past the top and far below the bottom
    send_request(make_request(MODE_GET, -1, 0, TAG_NIL, '0));
    send_request(make_request(MODE_GET, 255, 0, TAG_NIL, '0));
    send_request(make_request(MODE_GET, -256, 0, TAG_NIL, '0));
    // sets: relative, with the no-such-slot tag, and out of range
    send_request(make_request(MODE_SET, -2, 0, TAG_INTEGER, 64'h0123_4567_89ab_cdef));
    send_request(make_request(MODE_SET, 2, 0, TAG_NONE, '1));
    send_request(make_request(MODE_SET, 5, 0, TAG_BOOL, 64'h0));
    // rotates with small and large shift amounts of both signs wrapping around the segment
    send_request(make_request(MODE_ROTATE, 0, 1, TAG_NIL, '0));
    send_request(make_request(MODE_ROTATE, -3, -256, TAG_NIL, '0));
    send_request(make_request(MODE_ROTATE, 1, 256, TAG_NIL, '0));
    send_request(make_request(MODE_UNUSED_6, 0, 0, TAG_BOOL, '1));
    send_request(make_request(MODE_UNUSED_7, -1, -1, TAG_BOOL, '1));
    // set_top below the bottom, then fill to one short of full, then overflow a push
    send_request(make_request(MODE_SET_TOP, -7, 0, TAG_NIL, '0));
    send_request(make_request(MODE_SET_TOP, 255, 0, TAG_NIL, '0));
    send_request(make_request(MODE_PUSH, 0, 0, TAG_INTEGER, 64'hffff_0000_ffff_0000));
    send_request(make_request(MODE_PUSH, 0, 0, TAG_INTEGER, 64'h1));
    send_request(make_request(MODE_GET, 255, 0, TAG_NIL, '0));
    send_request(make_request(MODE_SET_TOP, 2, 0, TAG_NIL, '0));
    repeat (3) send_request(make_request(MODE_POP, 0, 0, TAG_NIL, '0));

    // random traffic steered by the mirrored depth; ignored modes do not count
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      if (counted % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      r = random_request(book.live);
      send_request(r);
      if (r.mode <= MODE_SET_TOP) counted++;
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (book.pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.errors == 0 && book.pending_words.size() == 0) begin
      $display("tagged_value_stack_engine_unit verification clean");
    end else begin
      $display("tagged_value_stack_engine_unit verification failed");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run with every rotate spanning the full stack
  initial begin
    #80_000_000;
    $display("tagged_value_stack_engine_unit verification failed");
    $finish;
  end

endmodule

// ===== tagged_value_stack_engine_unit.f =====
+incdir+rtl/core
rtl/core/tvse_pkg.sv
rtl/core/tvse_rem.sv
rtl/core/tvse_dp.sv
rtl/core/tvse_ctrl.sv
rtl/core/tagged_value_stack_engine_unit.sv
rtl/core/tvse_checker.sv
bench/tb_tagged_value_stack_engine_unit.sv
